@@ hdl/sls16_pkg.sv @@
package sls16_pkg;

    // configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LEN = 1'b0,
        CFG_SYNC    = 1'b1
    } t_cfg_index;

    localparam logic [15:0] MAX_LEN_RESET = 16'd300;
    localparam logic [15:0] SYNC_RESET    = 16'h4A54;

    typedef struct packed {
        logic [15:0] max_len;
        logic [15:0] sync_word;
    } t_cfg;

    // header offsets within a frame
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_FIRST_HDR = 5'd2;
    localparam logic [POS_W-1:0] POS_ADDR_LAST = 5'd9;
    localparam logic [POS_W-1:0] POS_TYPE      = 5'd13;
    localparam logic [POS_W-1:0] POS_CMD_HI    = 5'd15;
    localparam logic [POS_W-1:0] POS_CMD_LO    = 5'd16;
    localparam logic [POS_W-1:0] POS_LEN_HI    = 5'd17;
    localparam logic [POS_W-1:0] POS_LEN_LO    = 5'd18;

    typedef enum logic [2:0] {
        PH_HUNT1    = 3'd0,
        PH_HUNT2    = 3'd1,
        PH_HEADER   = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_TRAIL_HI = 3'd4,
        PH_TRAIL_LO = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD    = 2'd0,
        KIND_GOOD       = 2'd1,
        KIND_BAD_SUM    = 2'd2,
        KIND_OVER_LIMIT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [63:0] device_address;
        logic [7:0]  frame_type;
        logic [15:0] command_word;
        logic [15:0] payload_length;
        logic [15:0] received_checksum;
        logic [15:0] computed_checksum;
    } t_result;

endpackage

@@ hdl/sls16_if.sv @@
interface sls16_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sls16_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [63:0] device_address;
    logic [7:0]  frame_type;
    logic [15:0] command_word;
    logic [15:0] payload_length;
    logic [15:0] received_checksum;
    logic [15:0] computed_checksum;

    modport source (
        output valid, output kind, output payload_byte, output payload_index,
        output device_address, output frame_type, output command_word,
        output payload_length, output received_checksum, output computed_checksum,
        input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input payload_index,
        input device_address, input frame_type, input command_word,
        input payload_length, input received_checksum, input computed_checksum,
        output ready
    );
endinterface

@@ hdl/sls16_cfg.sv @@
module sls16_cfg
    import sls16_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (t_cfg_index'(i_index))
                CFG_MAX_LEN: n_cfg.max_len   = i_data;
                CFG_SYNC:    n_cfg.sync_word = i_data;
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len   <= MAX_LEN_RESET;
            r_cfg.sync_word <= SYNC_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/sls16_parser.sv @@
module sls16_parser
    import sls16_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_pidx, n_pidx;
    logic [15:0]      r_sum, n_sum;
    logic [63:0]      r_addr, n_addr;
    logic [7:0]       r_type, n_type;
    logic [15:0]      r_cmd, n_cmd;
    logic [15:0]      r_len, n_len;
    logic [7:0]       r_thi, n_thi;

    logic [7:0]  s_hi;
    logic [7:0]  s_lo;
    logic [15:0] rcv_sum;
    logic [16:0] pidx_next;

    assign s_hi      = i_cfg.sync_word[15:8];
    assign s_lo      = i_cfg.sync_word[7:0];
    assign rcv_sum   = {r_thi, i_byte};
    assign pidx_next = {1'b0, r_pidx} + 17'd1;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_pidx      = r_pidx;
        n_sum       = r_sum;
        n_addr      = r_addr;
        n_type      = r_type;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_thi       = r_thi;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT2: begin
                    if (i_byte == s_lo) begin
                        n_sum   = {8'h00, s_hi} + {8'h00, s_lo};
                        n_pos   = POS_FIRST_HDR;
                        n_phase = PH_HEADER;
                    end else if (i_byte != s_hi) begin
                        n_phase = PH_HUNT1;
                    end
                end
                PH_HEADER: begin
                    n_sum = r_sum + {8'h00, i_byte};
                    if (r_pos <= POS_ADDR_LAST) begin
                        n_addr = {r_addr[55:0], i_byte};
                    end else if (r_pos == POS_TYPE) begin
                        n_type = i_byte;
                    end else if (r_pos == POS_CMD_HI || r_pos == POS_CMD_LO) begin
                        n_cmd = {r_cmd[7:0], i_byte};
                    end else if (r_pos == POS_LEN_HI || r_pos == POS_LEN_LO) begin
                        n_len = {r_len[7:0], i_byte};
                    end
                    if (r_pos == POS_LEN_LO) begin
                        n_pidx = '0;
                        if (n_len > i_cfg.max_len) begin
                            n_phase     = PH_HUNT1;
                            o_res_valid = 1'b1;
                            o_res.kind  = KIND_OVER_LIMIT;
                        end else if (n_len == 16'd0) begin
                            n_phase = PH_TRAIL_HI;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_sum               = r_sum + {8'h00, i_byte};
                    o_res_valid         = 1'b1;
                    o_res.kind          = KIND_PAYLOAD;
                    o_res.payload_byte  = i_byte;
                    o_res.payload_index = r_pidx;
                    n_pidx              = pidx_next[15:0];
                    if (pidx_next >= {1'b0, r_len}) begin
                        n_phase = PH_TRAIL_HI;
                    end
                end
                PH_TRAIL_HI: begin
                    n_thi   = i_byte;
                    n_phase = PH_TRAIL_LO;
                end
                PH_TRAIL_LO: begin
                    n_phase                 = PH_HUNT1;
                    o_res_valid             = 1'b1;
                    o_res.kind              = (rcv_sum == r_sum) ? KIND_GOOD : KIND_BAD_SUM;
                    o_res.received_checksum = rcv_sum;
                    o_res.computed_checksum = r_sum;
                end
                default: begin
                    // first sync byte hunt, also unused phase codes
                    n_phase = (i_byte == s_hi) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end

        // header fields travel with every result
        o_res.device_address = n_addr;
        o_res.frame_type     = n_type;
        o_res.command_word   = n_cmd;
        o_res.payload_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_pos   <= '0;
            r_pidx  <= '0;
            r_sum   <= '0;
            r_addr  <= '0;
            r_type  <= '0;
            r_cmd   <= '0;
            r_len   <= '0;
            r_thi   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_pidx  <= n_pidx;
            r_sum   <= n_sum;
            r_addr  <= n_addr;
            r_type  <= n_type;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_thi   <= n_thi;
        end
    end

    a_pidx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_pidx < r_len)
        else $error("payload index reached frame length");

    a_over_limit_rehunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_OVER_LIMIT) |=> r_phase == PH_HUNT1)
        else $error("hunt did not resume after oversized frame");

    a_trailer_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TRAIL_LO && $past(r_phase) != PH_TRAIL_LO)
            |-> $past(r_phase) == PH_TRAIL_HI)
        else $error("trailer low byte phase entered out of order");

    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> (r_pos >= POS_FIRST_HDR && r_pos <= POS_LEN_LO))
        else $error("header offset out of range");

endmodule

@@ hdl/sls16_out_stage.sv @@
module sls16_out_stage
    import sls16_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_valid;
    t_result r_res;

    // room for a new result when empty or when the held one leaves now
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_load_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> o_space)
        else $error("result overwrote one still waiting");

endmodule

@@ hdl/sync_length_sum16_deframer.sv @@
// channel   dir  transaction                      payload
// i_rx      in   one received byte                rx_byte
// o_res     out  payload byte or frame verdict    kind, payload_byte, payload_index,
//                                                 header fields, checksums
// i_cfg_*   in   register write (0 max length, 1 sync word)
//
// one byte per cycle: each byte passes the parser logic in the cycle it is
// taken and its result, if any, sits in the output register the next cycle
// i_rx.ready is high while the output register is empty or being drained,
// so the stream keeps full rate as long as results are taken
// synchronous active-low reset returns to the sync hunt and restores
// max length 300 and sync word 0x4A54
module sync_length_sum16_deframer
    import sls16_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sls16_rx_if.sink              i_rx,
    sls16_res_if.source           o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    logic    accept;
    logic    space;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign i_rx.ready = space;
    assign accept     = i_rx.valid && space;

    sls16_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    sls16_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_byte      (i_rx.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sls16_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_space     (space),
        .o_valid     (o_res.valid),
        .o_res       (out_res),
        .i_ready     (o_res.ready)
    );

    assign o_res.kind              = out_res.kind;
    assign o_res.payload_byte      = out_res.payload_byte;
    assign o_res.payload_index     = out_res.payload_index;
    assign o_res.device_address    = out_res.device_address;
    assign o_res.frame_type        = out_res.frame_type;
    assign o_res.command_word      = out_res.command_word;
    assign o_res.payload_length    = out_res.payload_length;
    assign o_res.received_checksum = out_res.received_checksum;
    assign o_res.computed_checksum = out_res.computed_checksum;

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sls16_pkg::*;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          PHASES      = 6;
    localparam logic [16:0] PAYLOAD_POS = 17'd19;
    localparam bit          PIN         = 1'b1;
    localparam bit          FREE        = 1'b0;

    typedef struct packed {
        logic [7:0] data;
        bit         pin;
        t_kind      kind;
    } t_step;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sls16_rx_if  rx_ch ();
    sls16_res_if res_ch ();

    sync_length_sum16_deframer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // deframer state as seen from the byte stream
    t_phase      hunt_state = PH_HUNT1;
    logic [16:0] frame_pos  = '0;
    logic [15:0] sum_acc    = '0;
    logic [63:0] addr_acc   = '0;
    logic [7:0]  type_acc   = '0;
    logic [15:0] cmd_acc    = '0;
    logic [15:0] len_acc    = '0;
    logic [7:0]  trail_hi   = '0;
    logic [15:0] len_limit  = MAX_LEN_RESET;
    logic [15:0] sync_pat   = SYNC_RESET;

    t_result     outputs_due[$];
    int          mismatches    = 0;
    int          cycle_count   = 0;
    int          src_idle_pct  = 30;
    int          sink_idle_pct = 81;
    int unsigned stream_bytes  = 0;

    logic [15:0] limit_set [PHASES] = '{16'd300, 16'd0, 16'hFFFF, 16'd20, 16'd8, 16'd300};
    logic [15:0] sync_set  [PHASES] = '{16'h4A54, 16'h0000, 16'hFFFF, 16'h4A4A, 16'h4A54,
                                       16'h4A54};

    // slid sync and over-limit header at the extremes, then a one-byte frame with a bad sum
    t_step directed_steps [43] = '{
        '{8'h54, FREE, KIND_PAYLOAD}, '{8'h4A, FREE, KIND_PAYLOAD},
        '{8'h4A, FREE, KIND_PAYLOAD}, '{8'h54, FREE, KIND_PAYLOAD},
        '{8'hFF, FREE, KIND_PAYLOAD}, '{8'hFF, FREE, KIND_PAYLOAD},
        '{8'hFF, FREE, KIND_PAYLOAD}, '{8'hFF, FREE, KIND_PAYLOAD},
        '{8'hFF, FREE, KIND_PAYLOAD}, '{8'hFF, FREE, KIND_PAYLOAD},
        '{8'hFF, FREE, KIND_PAYLOAD}, '{8'hFF, FREE, KIND_PAYLOAD},
        '{8'h00, FREE, KIND_PAYLOAD}, '{8'h00, FREE, KIND_PAYLOAD},
        '{8'h00, FREE, KIND_PAYLOAD}, '{8'h80, FREE, KIND_PAYLOAD},
        '{8'h00, FREE, KIND_PAYLOAD}, '{8'hFF, FREE, KIND_PAYLOAD},
        '{8'hFF, FREE, KIND_PAYLOAD}, '{8'hFF, FREE, KIND_PAYLOAD},
        '{8'hFF, PIN,  KIND_OVER_LIMIT},
        '{8'h4A, FREE, KIND_PAYLOAD}, '{8'h54, FREE, KIND_PAYLOAD},
        '{8'h00, FREE, KIND_PAYLOAD}, '{8'h00, FREE, KIND_PAYLOAD},
        '{8'h00, FREE, KIND_PAYLOAD}, '{8'h00, FREE, KIND_PAYLOAD},
        '{8'h00, FREE, KIND_PAYLOAD}, '{8'h00, FREE, KIND_PAYLOAD},
        '{8'h00, FREE, KIND_PAYLOAD}, '{8'h00, FREE, KIND_PAYLOAD},
        '{8'h00, FREE, KIND_PAYLOAD}, '{8'h00, FREE, KIND_PAYLOAD},
        '{8'h00, FREE, KIND_PAYLOAD}, '{8'hFF, FREE, KIND_PAYLOAD},
        '{8'h00, FREE, KIND_PAYLOAD}, '{8'h00, FREE, KIND_PAYLOAD},
        '{8'h00, FREE, KIND_PAYLOAD}, '{8'h00, FREE, KIND_PAYLOAD},
        '{8'h01, FREE, KIND_PAYLOAD}, '{8'hFF, PIN,  KIND_PAYLOAD},
        '{8'h00, FREE, KIND_PAYLOAD}, '{8'h00, PIN,  KIND_BAD_SUM}
    };

    task automatic deframe_byte(input logic [7:0] b, output bit made, output t_result res);
        logic [7:0]  s_hi;
        logic [7:0]  s_lo;
        logic [15:0] idx;
        s_hi = sync_pat[15:8];
        s_lo = sync_pat[7:0];
        made = 1'b0;
        res  = '0;
        case (hunt_state)
            PH_HUNT2: begin
                if (b == s_lo) begin
                    sum_acc    = 16'(s_hi) + 16'(s_lo);
                    frame_pos  = 17'(POS_FIRST_HDR);
                    hunt_state = PH_HEADER;
                end else if (b != s_hi) begin
                    hunt_state = PH_HUNT1;
                end
            end
            PH_HEADER: begin
                sum_acc = sum_acc + 16'(b);
                if (frame_pos <= 17'(POS_ADDR_LAST)) begin
                    addr_acc = {addr_acc[55:0], b};
                end else if (frame_pos == 17'(POS_TYPE)) begin
                    type_acc = b;
                end else if (frame_pos == 17'(POS_CMD_HI) || frame_pos == 17'(POS_CMD_LO)) begin
                    cmd_acc = {cmd_acc[7:0], b};
                end else if (frame_pos == 17'(POS_LEN_HI) || frame_pos == 17'(POS_LEN_LO)) begin
                    len_acc = {len_acc[7:0], b};
                end
                if (frame_pos == 17'(POS_LEN_LO)) begin
                    frame_pos = PAYLOAD_POS;
                    // limit is sampled here, so a write during the header still counts
                    if (len_acc > len_limit) begin
                        hunt_state = PH_HUNT1;
                        made       = 1'b1;
                        res.kind   = KIND_OVER_LIMIT;
                    end else begin
                        hunt_state = (len_acc == 16'd0) ? PH_TRAIL_HI : PH_PAYLOAD;
                    end
                end else begin
                    frame_pos = frame_pos + 17'd1;
                end
            end
            PH_PAYLOAD: begin
                idx               = 16'(frame_pos - PAYLOAD_POS);
                sum_acc           = sum_acc + 16'(b);
                made              = 1'b1;
                res.kind          = KIND_PAYLOAD;
                res.payload_byte  = b;
                res.payload_index = idx;
                frame_pos         = frame_pos + 17'd1;
                if (17'(idx) + 17'd1 >= 17'(len_acc)) hunt_state = PH_TRAIL_HI;
            end
            PH_TRAIL_HI: begin
                trail_hi   = b;
                hunt_state = PH_TRAIL_LO;
            end
            PH_TRAIL_LO: begin
                made                  = 1'b1;
                res.received_checksum = {trail_hi, b};
                res.computed_checksum = sum_acc;
                res.kind              = ({trail_hi, b} == sum_acc) ? KIND_GOOD : KIND_BAD_SUM;
                hunt_state            = PH_HUNT1;
            end
            default: begin
                hunt_state = (b == s_hi) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
        if (made) begin
            res.device_address = addr_acc;
            res.frame_type     = type_acc;
            res.command_word   = cmd_acc;
            res.payload_length = len_acc;
        end
    endtask

    // entered at a falling edge; leaves valid high after the transaction
    task automatic feed_byte(input logic [7:0] b, input bit pin = 1'b0,
                             input t_kind pin_kind = KIND_PAYLOAD);
        bit      made;
        t_result res;
        while ($urandom_range(99) < src_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (rx_ch.ready !== 1'b1);
        deframe_byte(b, made, res);
        if (pin) res.kind = pin_kind;
        if (made || pin) outputs_due.push_back(res);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [15:0] plen, input bit bad_sum,
                              input int unsigned cut);
        logic [7:0]  frame_q[$];
        logic [15:0] csum;
        int unsigned n;
        frame_q.push_back(sync_pat[15:8]);
        frame_q.push_back(sync_pat[7:0]);
        repeat (15) frame_q.push_back(8'($urandom));
        frame_q.push_back(plen[15:8]);
        frame_q.push_back(plen[7:0]);
        repeat (plen) frame_q.push_back(8'($urandom));
        csum = '0;
        foreach (frame_q[k]) csum = csum + 16'(frame_q[k]);
        if (bad_sum) csum = csum ^ 16'($urandom_range(1, 65535));
        frame_q.push_back(csum[15:8]);
        frame_q.push_back(csum[7:0]);
        n = (cut != 0 && cut < frame_q.size()) ? cut : frame_q.size();
        for (int k = 0; k < n; k++) feed_byte(frame_q[k]);
        stream_bytes += n;
    endtask

    task automatic settle();
        rx_ch.valid <= 1'b0;
        while (outputs_due.size() != 0) @(negedge i_clk);
        // a header byte may still be in the parser with nothing to show for it
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_LEN) len_limit = val;
        else sync_pat = val;
        @(negedge i_clk);
    endtask

    function automatic void cmp_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endfunction

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (outputs_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transaction, kind %0d", res_ch.kind);
            end else begin
                want = outputs_due.pop_front();
                cmp_field("kind", 64'(want.kind), 64'(res_ch.kind));
                cmp_field("payload_byte", 64'(want.payload_byte), 64'(res_ch.payload_byte));
                cmp_field("payload_index", 64'(want.payload_index), 64'(res_ch.payload_index));
                cmp_field("device_address", want.device_address, res_ch.device_address);
                cmp_field("frame_type", 64'(want.frame_type), 64'(res_ch.frame_type));
                cmp_field("command_word", 64'(want.command_word), 64'(res_ch.command_word));
                cmp_field("payload_length", 64'(want.payload_length),
                          64'(res_ch.payload_length));
                cmp_field("received_checksum", 64'(want.received_checksum),
                          64'(res_ch.received_checksum));
                cmp_field("computed_checksum", 64'(want.computed_checksum),
                          64'(res_ch.computed_checksum));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int unsigned roll;
        int unsigned cut;
        int unsigned cut_lo;
        int unsigned start;
        logic [15:0] plen;
        logic [7:0]  nb;

        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_MAX_LEN;
        cfg_data      <= '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_steps[i])
            feed_byte(directed_steps[i].data, directed_steps[i].pin, directed_steps[i].kind);

        for (int ph = 0; ph < PHASES; ph++) begin
            src_idle_pct  = (ph < 2) ? 30 : (ph < 4) ? 81 : 0;
            sink_idle_pct = (ph < 2) ? 81 : (ph < 4) ? 30 : 0;
            settle();
            write_reg(CFG_MAX_LEN, limit_set[ph]);
            write_reg(CFG_SYNC, (ph == 4) ? 16'($urandom) : sync_set[ph]);
            if (len_limit == 16'hFFFF) send_frame(16'd400, 1'b0, 0);
            // with no limit a cut inside the header could pick up a huge length
            cut_lo = (len_limit > 16'd300) ? 18 : 3;
            start  = stream_bytes;
            while (stream_bytes - start < 150) begin
                roll = $urandom_range(99);
                if (roll < 8) begin
                    repeat ($urandom_range(1, 4)) begin
                        do nb = 8'($urandom); while (nb == sync_pat[15:8]);
                        feed_byte(nb);
                    end
                end else if (roll < 16 && sync_pat[15:8] != sync_pat[7:0]) begin
                    repeat ($urandom_range(1, 3)) feed_byte(sync_pat[15:8]);
                end
                roll = $urandom_range(99);
                cut  = 0;
                if (roll < 8 && len_limit != 16'hFFFF) begin
                    plen = (roll < 3 || len_limit > 16'hFFF0) ? 16'hFFFF
                         : len_limit + 16'($urandom_range(1, 4));
                    cut  = 19;
                end else if (roll < 20) begin
                    plen = (len_limit < 16'd40) ? len_limit : 16'($urandom_range(13, 40));
                end else begin
                    plen = 16'($urandom_range(0, (len_limit < 16'd12) ? len_limit : 12));
                end
                if (cut == 0 && len_limit != 16'hFFFF && $urandom_range(99) < 5)
                    cut = $urandom_range(cut_lo, 32'(plen) + 20);
                send_frame(plen, $urandom_range(99) < 15, cut);
            end
            // leave the parser inside a frame so the next register writes land mid-frame
            if (ph != 1 && ph != PHASES - 1 && $urandom_range(1) == 1) begin
                plen = 16'($urandom_range(0, 12));
                send_frame(plen, 1'b0, $urandom_range(18, 32'(plen) + 20));
            end
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && outputs_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
